>>> rtl/core/wmh_pkg.sv
// Package with shared types and constants for the weighted min-hash sketch block.
package wmh_pkg;

  localparam int unsigned NodeW = 10;
  localparam int unsigned SlotW = 6;
  localparam int unsigned AddrW = NodeW + SlotW;
  localparam int unsigned ValW  = 32;
  localparam int unsigned IdxW  = 11;
  localparam int unsigned CntW  = 7;
  localparam logic [CntW-1:0] Hashes = 7'd64;

  localparam logic [1:0] FuncBeta  = 2'd0;
  localparam logic [1:0] FuncSlot  = 2'd1;
  localparam logic [1:0] FuncEdge  = 2'd2;
  localparam logic [1:0] FuncRead  = 2'd3;

  typedef struct packed {
    logic [1:0]      func;
    logic [SlotW-1:0] hash_slot;
    logic [NodeW-1:0] node_id;
    logic [NodeW-1:0] neighbor_id;
    logic [ValW-1:0] load_value;
    logic [IdxW-1:0] load_index;
    logic [15:0]     edge_weight;
    logic            last_edge;
  } item_t;

  typedef struct packed {
    logic            result_kind;
    logic            sketch_changed;
    logic [ValW-1:0] slot_value;
    logic [IdxW-1:0] slot_index;
  } result_t;

endpackage

>>> rtl/core/wmh_div.sv
// Restoring divider: (beta << 8) / weight, saturated to 32 bits, one bit per cycle.
module wmh_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] beta_i,
  input  logic [15:0] weight_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  // The dividend has 40 bits; a quotient needing more than 32 bits saturates.
  logic [39:0] num_q, num_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    trial  = {rem_q, num_q[39]};
    if (start_i) begin
      num_d  = {beta_i, 8'd0};
      rem_d  = '0;
      cnt_d  = 6'd40;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it always fits in 16 bits.
      if (trial >= {1'b0, den_q}) begin
        rem_d = 16'(trial - {1'b0, den_q});
        num_d = {num_q[38:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        num_d = {num_q[38:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quot_o = (num_d[39:32] != 8'd0) ? 32'hFFFF_FFFF : num_d[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) den_q <= weight_i;
  end

endmodule

>>> rtl/core/weighted_minhash_sketch_update.sv
// Weighted min-hash sketch update block: an edge is busy for its accept cycle plus, per hash
// slot in use, a memory read, a divider start, a bit-serial 40-bit divide and a compare and
// write back, so the bit-serial divider sets the time. A beta or slot write is done in its
// accept cycle; a read passes the registered memory read and StRdo, then its result beat
// leaves the registered outputs. Results are strobed on done_o for one cycle and cannot be stalled.
module weighted_minhash_sketch_update (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  wmh_pkg::item_t         item_i,
  input  logic                   cfg_we_i,
  input  logic [6:0]             cfg_data_i,
  output logic                   done_o,
  output wmh_pkg::result_t       result_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd   = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StWait = 3'd3;
  localparam logic [2:0] StCmp  = 3'd4;
  localparam logic [2:0] StRdo  = 3'd5;

  logic [31:0] beta_mem [2**wmh_pkg::AddrW];
  logic [31:0] val_mem  [2**wmh_pkg::AddrW];
  logic [10:0] idx_mem  [2**wmh_pkg::AddrW];

  logic [2:0]  st_q, st_d;
  logic [6:0]  hin_q;
  logic [6:0]  k_q, k_d;
  logic [6:0]  lim;
  wmh_pkg::item_t it_q;
  logic        chg_q, chg_d;
  logic        done_d;
  wmh_pkg::result_t res_q, res_d;

  logic [15:0] beta_ra, val_ra, wa;
  logic        beta_we, val_we;
  logic [31:0] beta_wd, val_wd, beta_rd, val_rd, qt, q_q;
  logic [10:0] idx_wd, idx_rd;
  logic        div_start, div_done;

  assign lim  = (hin_q > wmh_pkg::Hashes) ? wmh_pkg::Hashes : hin_q;
  assign busy = (st_q != StIdle);

  wmh_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .beta_i(beta_rd),
    .weight_i(it_q.edge_weight), .done_o(div_done), .quot_o(qt)
  );

  always_comb begin
    st_d = st_q; k_d = k_q; chg_d = chg_q; done_d = 1'b0; res_d = res_q;
    beta_ra = {k_q[5:0], it_q.neighbor_id};
    val_ra  = {it_q.node_id, k_q[5:0]};
    wa = val_ra; beta_we = 1'b0; val_we = 1'b0;
    beta_wd = item_i.load_value; val_wd = q_q;
    idx_wd = {1'b0, it_q.neighbor_id} + 11'd1;
    div_start = 1'b0;
    case (st_q)
      StIdle: begin
        if (start) begin
          case (item_i.func)
            wmh_pkg::FuncBeta: begin
              beta_we = 1'b1;
            end
            wmh_pkg::FuncSlot: begin
              val_we = 1'b1; val_wd = item_i.load_value; idx_wd = item_i.load_index;
            end
            wmh_pkg::FuncEdge: begin
              k_d = '0;
              if (lim == 7'd0) begin
                if (item_i.last_edge) begin
                  done_d = 1'b1; res_d = '0; res_d.sketch_changed = chg_q; chg_d = 1'b0;
                end
              end else begin
                st_d = StRd;
              end
            end
            default: begin
              st_d = StRdo;
            end
          endcase
          wa = {item_i.node_id, item_i.hash_slot};
          val_ra = wa;
          if (item_i.func == wmh_pkg::FuncBeta) wa = {item_i.hash_slot, item_i.neighbor_id};
        end
      end
      StRdo: begin
        done_d = 1'b1;
        res_d.result_kind = 1'b1; res_d.sketch_changed = 1'b0;
        res_d.slot_value = val_rd; res_d.slot_index = idx_rd;
        st_d = StIdle;
      end
      StRd: st_d = StDiv;
      StDiv: begin
        div_start = 1'b1; st_d = StWait;
      end
      StWait: if (div_done) st_d = StCmp;
      StCmp: begin
        if (q_q < val_rd) begin
          val_we = 1'b1; chg_d = 1'b1;
        end
        if (k_q + 7'd1 >= lim) begin
          st_d = StIdle;
          if (it_q.last_edge) begin
            done_d = 1'b1; res_d = '0;
            res_d.sketch_changed = chg_q | (q_q < val_rd); chg_d = 1'b0;
          end
        end else begin
          k_d = k_q + 7'd1; st_d = StRd;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (beta_we) beta_mem[wa] <= beta_wd;
    beta_rd <= beta_mem[beta_ra];
    if (val_we) begin
      val_mem[wa] <= val_wd;
      idx_mem[wa] <= idx_wd;
    end
    val_rd <= val_mem[val_ra];
    idx_rd <= idx_mem[val_ra];
    if (div_done) q_q <= qt;
    if (start && !busy) it_q <= item_i;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      k_q    <= '0;
      chg_q  <= 1'b0;
      hin_q  <= 7'd64;
      done_o <= 1'b0;
    end else begin
      st_q   <= st_d;
      k_q    <= k_d;
      chg_q  <= chg_d;
      done_o <= done_d;
      if (cfg_we_i) hin_q <= cfg_data_i;
    end
  end

  assign result_o = res_q;

endmodule
